// ----- design/fsa_pkg.sv -----
// Shared types, constants and register codes for the five-point stencil block.
package fsa_pkg;

  // Datapath widths
  localparam int DATA_W     = 32;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_OUT_W  = 10;
  localparam int BOUND_W    = 10;
  localparam int GRID_W     = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // Default sizing
  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int GRID_MIN     = 3;
  localparam int QUEUE_DEPTH  = 4;

  // Register reset values
  localparam logic [GRID_W-1:0]  RST_GRID_COLS = 11'd1024;
  localparam logic [GRID_W-1:0]  RST_GRID_ROWS = 11'd1024;
  localparam logic [BOUND_W-1:0] RST_FIRST_COL = 10'd1;
  localparam logic [BOUND_W-1:0] RST_LAST_COL  = 10'd1022;
  localparam logic [BOUND_W-1:0] RST_FIRST_ROW = 10'd1;
  localparam logic [BOUND_W-1:0] RST_LAST_ROW  = 10'd1022;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLS = 3'd0,
    CFG_GRID_ROWS = 3'd1,
    CFG_FIRST_COL = 3'd2,
    CFG_LAST_COL  = 3'd3,
    CFG_FIRST_ROW = 3'd4,
    CFG_LAST_ROW  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_cols;
    logic [GRID_W-1:0]  grid_rows;
    logic [BOUND_W-1:0] first_col;
    logic [BOUND_W-1:0] last_col;
    logic [BOUND_W-1:0] first_row;
    logic [BOUND_W-1:0] last_row;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] west;
    logic signed [DATA_W-1:0] east;
    logic signed [DATA_W-1:0] south;
    logic signed [DATA_W-1:0] north;
    logic signed [DATA_W-1:0] center;
  } coef_set_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
    logic                 last;
  } meta_t;

  // One word of work handed from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] uw;
    logic signed [DATA_W-1:0] ue;
    logic signed [DATA_W-1:0] us;
    logic signed [DATA_W-1:0] un;
    logic signed [DATA_W-1:0] uc;
    coef_set_t                coef;
    meta_t                    meta;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
    logic nearly_full;
  } q_status_t;

endpackage

// ----- design/fsa_if.sv -----
// Stream interfaces for the stencil input cells and the result words.
interface fsa_in_if;
  import fsa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] field_value;
  logic signed [DATA_W-1:0] coef_west;
  logic signed [DATA_W-1:0] coef_east;
  logic signed [DATA_W-1:0] coef_south;
  logic signed [DATA_W-1:0] coef_north;
  logic signed [DATA_W-1:0] coef_center;

  modport source (
    output valid, field_value, coef_west, coef_east, coef_south, coef_north, coef_center,
    input  ready
  );
  modport sink (
    input  valid, field_value, coef_west, coef_east, coef_south, coef_north, coef_center,
    output ready
  );
endinterface

interface fsa_out_if;
  import fsa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] stencil_value;
  logic [COL_OUT_W-1:0]     cell_col;
  logic [ROW_OUT_W-1:0]     cell_row;
  logic                     is_last;

  modport source (
    output valid, stencil_value, cell_col, cell_row, is_last,
    input  ready
  );
  modport sink (
    input  valid, stencil_value, cell_col, cell_row, is_last,
    output ready
  );
endinterface

// ----- design/fsa_queue.sv -----
// Short word queue decoupling the line-buffer front from the arithmetic back.
module fsa_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fsa_pkg::job_t      push_data_i,
  input  logic               pop_i,
  output fsa_pkg::job_t      pop_data_o,
  output fsa_pkg::q_status_t status_o
);
  import fsa_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            slot_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o           = slot_q[rd_ptr_q];
  assign status_o.empty       = (count_q == '0);
  assign status_o.full        = (32'(count_q) == QUEUE_DEPTH);
  assign status_o.nearly_full = (32'(count_q) >= QUEUE_DEPTH - 1);

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !status_o.full)
    else $error("fsa_queue: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !status_o.empty)
    else $error("fsa_queue: pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1))
    else $error("fsa_queue: fill count lost a push");

endmodule

// ----- design/fsa_front.sv -----
// Front end: raster position, bounds classification, line buffers and window.
module fsa_front #(
  parameter int MAX_COLS = fsa_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = fsa_pkg::DEF_MAX_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsa_pkg::cfg_t      cfg_i,
  fsa_in_if.sink             in_i,
  input  fsa_pkg::q_status_t q_status_i,
  output logic               push_o,
  output fsa_pkg::job_t      job_o
);
  import fsa_pkg::*;

  localparam int ColW       = $clog2(MAX_COLS);
  localparam int ColCntW    = $clog2(MAX_COLS + 1);
  localparam int RowW       = $clog2(MAX_ROWS);
  localparam int RowCntW    = $clog2(MAX_ROWS + 1);
  localparam int FieldDepth = 2 ** (ColW + 1);

  typedef struct packed {
    logic                     emit;
    meta_t                    meta;
    logic signed [DATA_W-1:0] north;
  } stage_t;

  logic                  accept;
  logic [ColCntW-1:0]    cols_eff, cols_m2, lc;
  logic [RowCntW-1:0]    rows_eff, rows_m2, lr;
  logic [BOUND_W-1:0]    fc, fr;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d, row_m1;
  logic                  col_wrap, row_wrap;
  logic                  col_hit, row_hit, last_hit;
  logic [ColW:0]         win_addr, south_addr, wr_addr;

  logic signed [DATA_W-1:0] field_mem [FieldDepth];
  coef_set_t                coef_mem  [MAX_COLS];
  coef_set_t                coef_wr, coef_rd_q;
  logic signed [DATA_W-1:0] win_rd_q, south_rd_q;
  logic signed [DATA_W-1:0] win_c_q, win_w_q;

  logic   s1_v_q;
  stage_t st_q, st_d;

  assign in_i.ready = rst_ni && !q_status_i.nearly_full;
  assign accept     = in_i.valid && in_i.ready;

  // Effective grid size and bounds
  always_comb begin
    if (32'(cfg_i.grid_cols) < GRID_MIN) begin
      cols_eff = ColCntW'(GRID_MIN);
    end else if (32'(cfg_i.grid_cols) > MAX_COLS) begin
      cols_eff = ColCntW'(MAX_COLS);
    end else begin
      cols_eff = ColCntW'(cfg_i.grid_cols);
    end
    if (32'(cfg_i.grid_rows) < GRID_MIN) begin
      rows_eff = RowCntW'(GRID_MIN);
    end else if (32'(cfg_i.grid_rows) > MAX_ROWS) begin
      rows_eff = RowCntW'(MAX_ROWS);
    end else begin
      rows_eff = RowCntW'(cfg_i.grid_rows);
    end
    cols_m2 = cols_eff - ColCntW'(2);
    rows_m2 = rows_eff - RowCntW'(2);
    lc = (32'(cfg_i.last_col) < 32'(cols_m2)) ? ColCntW'(cfg_i.last_col) : cols_m2;
    lr = (32'(cfg_i.last_row) < 32'(rows_m2)) ? RowCntW'(cfg_i.last_row) : rows_m2;
    fc = (cfg_i.first_col == '0) ? BOUND_W'(1) : cfg_i.first_col;
    fr = (cfg_i.first_row == '0) ? BOUND_W'(1) : cfg_i.first_row;
  end

  // Classification of the arriving cell; the result belongs to the row above
  always_comb begin
    row_m1   = row_q - RowW'(1);
    col_hit  = (32'(col_q) >= 32'(fc)) && (32'(col_q) <= 32'(lc));
    row_hit  = (row_q != '0) && (32'(row_m1) >= 32'(fr)) && (32'(row_m1) <= 32'(lr));
    last_hit = (32'(col_q) == 32'(lc)) && (32'(row_m1) == 32'(lr));
    col_wrap = (32'(col_q) + 32'd1) >= 32'(cols_eff);
    row_wrap = (32'(row_q) + 32'd1) >= 32'(rows_eff);

    st_d.emit       = col_hit && row_hit;
    st_d.meta.col   = COL_OUT_W'(col_q);
    st_d.meta.row   = ROW_OUT_W'(row_m1);
    st_d.meta.last  = last_hit;
    st_d.north      = in_i.field_value;
  end

  // Raster position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= accept;
    end
  end

  // Line-buffer addresses: window runs one column ahead, wrapping to the
  // head of the row just finished at the end of a row
  always_comb begin
    if (col_wrap) begin
      win_addr = {row_q[0], ColW'(0)};
    end else begin
      win_addr = {~row_q[0], col_q + ColW'(1)};
    end
    south_addr = {row_q[0], col_q};
    wr_addr    = {row_q[0], col_q};
  end

  assign coef_wr = '{west:   in_i.coef_west,
                     east:   in_i.coef_east,
                     south:  in_i.coef_south,
                     north:  in_i.coef_north,
                     center: in_i.coef_center};

  // Field line buffer: one write, two registered reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      field_mem[wr_addr] <= in_i.field_value;
      win_rd_q           <= field_mem[win_addr];
      south_rd_q         <= field_mem[south_addr];
    end
  end

  // Coefficient row delay
  always_ff @(posedge clk_i) begin
    if (accept) begin
      coef_mem[col_q] <= coef_wr;
      coef_rd_q       <= coef_mem[col_q];
    end
  end

  // Stage payload and three-tap window over the previous row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
    if (s1_v_q) begin
      win_c_q <= win_rd_q;
      win_w_q <= win_c_q;
    end
  end

  assign push_o = s1_v_q && st_q.emit;

  always_comb begin
    job_o.uw   = win_w_q;
    job_o.uc   = win_c_q;
    job_o.ue   = win_rd_q;
    job_o.us   = south_rd_q;
    job_o.un   = st_q.north;
    job_o.coef = coef_rd_q;
    job_o.meta = st_q.meta;
  end

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> s1_v_q)
    else $error("fsa_front: accepted word lost before line-buffer stage");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !q_status_i.full)
    else $error("fsa_front: push with no queue space reserved");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> st_q.meta.col != '0)
    else $error("fsa_front: emitted a ghost column");

endmodule

// ----- design/fsa_back.sv -----
// Back end: five products, adder tree, floor shift, saturation, output register.
module fsa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsa_pkg::job_t      job_i,
  input  fsa_pkg::q_status_t q_status_i,
  output logic               pop_o,
  fsa_out_if.source          out_o
);
  import fsa_pkg::*;

  localparam int ProdW  = 2 * DATA_W;
  localparam int SumW   = ProdW + 2;
  localparam int FracW  = 16;
  localparam int FloorW = SumW - FracW;
  localparam logic signed [FloorW-1:0] SatMax = FloorW'(64'sd2147483647);
  localparam logic signed [FloorW-1:0] SatMin = FloorW'(-64'sd2147483648);

  logic en;
  logic m_v_q, a_v_q, s_v_q, o_v_q;

  logic signed [ProdW-1:0]  m_pw_q, m_pe_q, m_ps_q, m_pn_q, m_pc_q;
  meta_t                    m_meta_q, a_meta_q, s_meta_q, o_meta_q;
  logic signed [SumW-1:0]   a_s01_q, a_s23_q, a_pcn_q;
  logic signed [SumW-1:0]   s_sum_q;
  logic signed [FloorW-1:0] s_floor;
  logic signed [DATA_W-1:0] sat_d, o_val_q;

  // Whole pipe advances unless the output word is stalled
  assign en    = !o_v_q || out_o.ready;
  assign pop_o = en && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
      s_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= pop_o;
      a_v_q <= m_v_q;
      s_v_q <= a_v_q;
      o_v_q <= s_v_q;
    end
  end

  // Floor of the Q34.32 sum to Q34.16, then clamp to 32-bit Q16.16
  always_comb begin
    s_floor = $signed(s_sum_q[SumW-1:FracW]);
    if (s_floor > SatMax) begin
      sat_d = DATA_W'(SatMax);
    end else if (s_floor < SatMin) begin
      sat_d = DATA_W'(SatMin);
    end else begin
      sat_d = DATA_W'(s_floor);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // products
      m_pw_q   <= $signed(job_i.coef.west)   * $signed(job_i.uw);
      m_pe_q   <= $signed(job_i.coef.east)   * $signed(job_i.ue);
      m_ps_q   <= $signed(job_i.coef.south)  * $signed(job_i.us);
      m_pn_q   <= $signed(job_i.coef.north)  * $signed(job_i.un);
      m_pc_q   <= $signed(job_i.coef.center) * $signed(job_i.uc);
      m_meta_q <= job_i.meta;
      // pairwise sums, centre term negated
      a_s01_q  <= SumW'(m_pw_q) + SumW'(m_pe_q);
      a_s23_q  <= SumW'(m_ps_q) + SumW'(m_pn_q);
      a_pcn_q  <= -SumW'(m_pc_q);
      a_meta_q <= m_meta_q;
      // final sum
      s_sum_q  <= a_s01_q + a_s23_q + a_pcn_q;
      s_meta_q <= a_meta_q;
      // output register
      o_val_q  <= sat_d;
      o_meta_q <= s_meta_q;
    end
  end

  assign out_o.valid         = o_v_q;
  assign out_o.stencil_value = o_val_q;
  assign out_o.cell_col      = o_meta_q.col;
  assign out_o.cell_row      = o_meta_q.row;
  assign out_o.is_last       = o_meta_q.last;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> m_v_q)
    else $error("fsa_back: popped word missing from product stage");

endmodule

// ----- design/five_point_stencil_apply_unit.sv -----
// Five-point variable-coefficient stencil: one grid cell per word, raster order.
// Throughput: one cell per cycle while the result side takes words.
// A result goes through the line-buffer read, queue, product, adder tree, sum and output register
// in turn, starting from the edge that takes its north neighbour.
// Reset: position counters to zero, registers to defaults; line buffers not cleared.
// Configuration registers update on the edge of the write; no read-back.
module five_point_stencil_apply_unit #(
  parameter int MAX_COLS = fsa_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = fsa_pkg::DEF_MAX_ROWS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fsa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  fsa_in_if.sink                         in_i,
  fsa_out_if.source                      out_o
);
  import fsa_pkg::*;

  cfg_t      cfg_q, cfg_d;
  job_t      push_job, pop_job;
  logic      push, pop;
  q_status_t q_status;

  // Register file writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_COLS: cfg_d.grid_cols = cfg_wdata_i;
        CFG_GRID_ROWS: cfg_d.grid_rows = cfg_wdata_i;
        CFG_FIRST_COL: cfg_d.first_col = cfg_wdata_i[BOUND_W-1:0];
        CFG_LAST_COL:  cfg_d.last_col  = cfg_wdata_i[BOUND_W-1:0];
        CFG_FIRST_ROW: cfg_d.first_row = cfg_wdata_i[BOUND_W-1:0];
        CFG_LAST_ROW:  cfg_d.last_row  = cfg_wdata_i[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_cols <= RST_GRID_COLS;
      cfg_q.grid_rows <= RST_GRID_ROWS;
      cfg_q.first_col <= RST_FIRST_COL;
      cfg_q.last_col  <= RST_LAST_COL;
      cfg_q.first_row <= RST_FIRST_ROW;
      cfg_q.last_row  <= RST_LAST_ROW;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fsa_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  fsa_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (q_status)
  );

  fsa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (pop_job),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// ----- dv/five_point_stencil_apply_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the five-point stencil unit: grids in raster order, scoreboard.
module five_point_stencil_apply_unit_tb;
  import fsa_pkg::*;

  // One input word and one result word as the scoreboard sees them
  typedef struct packed {
    logic signed [DATA_W-1:0] field;
    coef_set_t                coef;
  } cell_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    meta_t                    meta;
  } stencil_t;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [67:0] SUM_HI = 68'sd2147483647;
  localparam logic signed [67:0] SUM_LO = -SUM_HI - 68'sd1;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 750;
  localparam int TALL_CELLS   = 240;
  localparam logic [DATA_W-1:0] CORNER_WORDS [7] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  fsa_in_if  in_if ();
  fsa_out_if out_if ();

  five_point_stencil_apply_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Scoreboard state
  cfg_t                     cfg_model;
  logic signed [DATA_W-1:0] field_line [2*DEF_MAX_COLS];
  coef_set_t                coef_line [DEF_MAX_COLS];
  int unsigned              col_pos;
  int unsigned              row_pos;
  stencil_t                 pending_stencils [$];
  int unsigned              mismatches = 0;
  bit                       idling = 1'b1;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned eff_cols();
    if (cfg_model.grid_cols < GRID_MIN) return GRID_MIN;
    if (cfg_model.grid_cols > DEF_MAX_COLS) return DEF_MAX_COLS;
    return cfg_model.grid_cols;
  endfunction

  function automatic int unsigned eff_rows();
    if (cfg_model.grid_rows < GRID_MIN) return GRID_MIN;
    if (cfg_model.grid_rows > DEF_MAX_ROWS) return DEF_MAX_ROWS;
    return cfg_model.grid_rows;
  endfunction

  // Predict the stencil result (if any) of one accepted cell, then update the line stores
  function automatic void predict_stencil(input cell_t cell_word);
    int unsigned cols, rows, c, r, rs, cur, prev, fc, lc, fr, lr;
    logic signed [63:0] p_w, p_e, p_s, p_n, p_c;
    logic signed [67:0] acc, sh;
    stencil_t res;
    cols = eff_cols();
    rows = eff_rows();
    c    = col_pos;
    r    = row_pos;
    rs   = r - 1;
    cur  = (r % 2) * DEF_MAX_COLS;
    prev = ((r + 1) % 2) * DEF_MAX_COLS;
    fc   = (cfg_model.first_col < 1) ? 1 : cfg_model.first_col;
    lc   = (cfg_model.last_col < cols - 2) ? cfg_model.last_col : cols - 2;
    fr   = (cfg_model.first_row < 1) ? 1 : cfg_model.first_row;
    lr   = (cfg_model.last_row < rows - 2) ? cfg_model.last_row : rows - 2;
    // incoming cell is the north neighbour of (c, r-1)
    if (r >= 2 && c >= fc && c <= lc && rs >= fr && rs <= lr) begin
      p_w = coef_line[c].west   * field_line[prev + c - 1];
      p_e = coef_line[c].east   * field_line[prev + c + 1];
      p_s = coef_line[c].south  * field_line[cur + c];
      p_n = coef_line[c].north  * cell_word.field;
      p_c = coef_line[c].center * field_line[prev + c];
      acc = p_w + p_e + p_s + p_n - p_c;
      sh  = acc >>> 16;
      if (sh > SUM_HI) res.value = Q_MAX;
      else if (sh < SUM_LO) res.value = Q_MIN;
      else res.value = sh[DATA_W-1:0];
      res.meta.col  = c[COL_OUT_W-1:0];
      res.meta.row  = rs[ROW_OUT_W-1:0];
      res.meta.last = (c == lc) && (rs == lr);
      pending_stencils.push_back(res);
    end
    field_line[cur + c] = cell_word.field;
    coef_line[c]        = cell_word.coef;
    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // Mix of small Q16.16 values, full-range words and corner words
  function automatic logic [DATA_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    if (pick < 8) return $urandom;
    return CORNER_WORDS[$urandom_range(0, 6)];
  endfunction

  function automatic cell_t random_cell();
    cell_t cell_word;
    cell_word.field       = rand_word();
    cell_word.coef.west   = rand_word();
    cell_word.coef.east   = rand_word();
    cell_word.coef.south  = rand_word();
    cell_word.coef.north  = rand_word();
    cell_word.coef.center = rand_word();
    return cell_word;
  endfunction

  // Send one cell word; optional gap first, valid stays high afterwards
  task automatic send_cell(input cell_t cell_word);
    @(negedge clk_i);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.field_value <= cell_word.field;
    in_if.coef_west   <= cell_word.coef.west;
    in_if.coef_east   <= cell_word.coef.east;
    in_if.coef_south  <= cell_word.coef.south;
    in_if.coef_north  <= cell_word.coef.north;
    in_if.coef_center <= cell_word.coef.center;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_stencil(cell_word);
  endtask

  // Stop sending and wait until every expected word has come out
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_stencils.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GRID_COLS: cfg_model.grid_cols = data;
      CFG_GRID_ROWS: cfg_model.grid_rows = data;
      CFG_FIRST_COL: cfg_model.first_col = data[BOUND_W-1:0];
      CFG_LAST_COL:  cfg_model.last_col  = data[BOUND_W-1:0];
      CFG_FIRST_ROW: cfg_model.first_row = data[BOUND_W-1:0];
      CFG_LAST_ROW:  cfg_model.last_row  = data[BOUND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_layout(input logic [CFG_DATA_W-1:0] cols, rows, fc, lc, fr, lr);
    cfg_write(CFG_GRID_COLS, cols);
    cfg_write(CFG_GRID_ROWS, rows);
    cfg_write(CFG_FIRST_COL, fc);
    cfg_write(CFG_LAST_COL, lc);
    cfg_write(CFG_FIRST_ROW, fr);
    cfg_write(CFG_LAST_ROW, lr);
  endtask

  // Bounds only; safe mid-grid since no line-store entry moves
  task automatic random_bounds();
    int unsigned cols, rows;
    logic [CFG_DATA_W-1:0] w [4];
    cols = eff_cols();
    rows = eff_rows();
    if ($urandom_range(0, 2) == 0) begin
      w[0] = CFG_DATA_W'($urandom_range(0, 1));
      w[1] = CFG_DATA_W'($urandom_range(cols - 2, 1023));
      w[2] = CFG_DATA_W'($urandom_range(0, 1));
      w[3] = CFG_DATA_W'($urandom_range(rows - 2, 1023));
    end else begin
      w[0] = CFG_DATA_W'($urandom_range(0, cols));
      w[1] = CFG_DATA_W'($urandom_range(0, cols));
      w[2] = CFG_DATA_W'($urandom_range(0, rows));
      w[3] = CFG_DATA_W'($urandom_range(0, rows));
    end
    // top bit lies outside the 10-bit bound registers
    foreach (w[i]) w[i][CFG_DATA_W-1] = 1'($urandom_range(0, 1));
    cfg_write(CFG_FIRST_COL, w[0]);
    cfg_write(CFG_LAST_COL, w[1]);
    cfg_write(CFG_FIRST_ROW, w[2]);
    cfg_write(CFG_LAST_ROW, w[3]);
  endtask

  task automatic send_random_grid();
    int unsigned cells;
    cells = eff_cols() * eff_rows();
    for (int unsigned i = 0; i < cells; i++) send_cell(random_cell());
  endtask

  // Full-scale operands: first result saturates high, second saturates low
  task automatic test_saturation();
    cell_t cell_word;
    set_layout(11'd0, 11'd4, 11'd0, 11'd1023, 11'd0, 11'd1023);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        cell_word.field = Q_MAX;
        case (r)
          1:       cell_word.coef = '{default: Q_MAX};
          2:       cell_word.coef = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX};
          default: cell_word.coef = '0;
        endcase
        send_cell(cell_word);
      end
    end
    drain_results();
  endtask

  // Row range with first above last: grid streams, no word comes out
  task automatic test_empty_range();
    set_layout(11'd2, 11'd2, 11'd1, 11'd1, 11'd1, 11'd0);
    send_random_grid();
    drain_results();
  endtask

  // Small random grids, back to back, with a bounds change part-way through some
  task automatic test_random_grids();
    int unsigned sent, cells, brk, iter;
    sent = 0;
    iter = 0;
    while (sent < RANDOM_ITEMS) begin
      idling = ($urandom_range(0, 3) != 0);
      cfg_write(CFG_GRID_COLS, CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                                      : $urandom_range(3, 12)));
      cfg_write(CFG_GRID_ROWS, CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                                      : $urandom_range(3, 10)));
      random_bounds();
      repeat ($urandom_range(1, 3)) begin
        cells = eff_cols() * eff_rows();
        brk = (iter == 0 || $urandom_range(0, 4) == 0) ? $urandom_range(1, cells - 1) : cells;
        for (int unsigned i = 0; i < cells; i++) begin
          // hold off until the pipe is empty, then move the bounds
          if (i == brk) begin
            drain_results();
            random_bounds();
          end
          send_cell(random_cell());
        end
        sent += cells;
        iter++;
      end
      drain_results();
    end
  endtask

  // Grid height clamped to the maximum: the leading rows, run without any idling
  task automatic test_tall_grid();
    idling = 1'b0;
    set_layout(11'd3, 11'd2047, 11'd1, 11'd1, 11'd1, 11'd1023);
    for (int unsigned i = 0; i < TALL_CELLS; i++) send_cell(random_cell());
    drain_results();
  endtask

  // Result side: ready dropped in random bursts
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idling && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin : check_results
    stencil_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_stencils.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: value %h col %0d row %0d last %b",
                   out_if.stencil_value, out_if.cell_col, out_if.cell_row, out_if.is_last);
      end else begin
        want = pending_stencils.pop_front();
        if (out_if.stencil_value !== want.value || out_if.cell_col !== want.meta.col ||
            out_if.cell_row !== want.meta.row || out_if.is_last !== want.meta.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: want %h (%0d,%0d) last %b, got %h (%0d,%0d) last %b",
                     want.value, want.meta.col, want.meta.row, want.meta.last,
                     out_if.stencil_value, out_if.cell_col, out_if.cell_row, out_if.is_last);
        end
      end
    end
  end

  // Main sequence
  initial begin
    in_if.valid       = 1'b0;
    in_if.field_value = '0;
    in_if.coef_west   = '0;
    in_if.coef_east   = '0;
    in_if.coef_south  = '0;
    in_if.coef_north  = '0;
    in_if.coef_center = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_GRID_COLS;
    cfg_wdata_i       = '0;
    cfg_model = '{RST_GRID_COLS, RST_GRID_ROWS, RST_FIRST_COL, RST_LAST_COL,
                  RST_FIRST_ROW, RST_LAST_ROW};
    col_pos = 0;
    row_pos = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_saturation();
    test_empty_range();
    test_random_grids();
    test_tall_grid();

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fsa_pkg.sv
design/fsa_if.sv
design/fsa_queue.sv
design/fsa_front.sv
design/fsa_back.sv
design/five_point_stencil_apply_unit.sv
dv/five_point_stencil_apply_unit_tb.sv
